[src/ihb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihb_pkg
// Shared widths, function and register codes, controller command and status
// types, and the constant function that builds the sigmoid probability table.
// ----------------------------------------------------------------------------
package ihb_pkg;

  localparam int COORD_W    = 6;
  localparam int FIX_W      = 16;
  localparam int SUM_W      = 19;
  localparam int SIZE_W     = 7;
  localparam int BETA_W     = 16;
  localparam int PROB_W     = 17;
  localparam int PROD_W     = 36;
  localparam int ARG_W      = 24;
  localparam int NBR_W      = 4;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD  = 2'd3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [BETA_W-1:0] BETA_RESET   = 16'd256;

  localparam logic [63:0] ONE_Q24 = 64'd16777216;

  typedef struct packed {
    logic capture;
    logic fetch_a;
    logic fetch_b;
    logic sum;
    logic scale;
    logic lookup;
    logic finish;
  } ihb_cmd_t;

  typedef struct packed {
    logic update_go;
  } ihb_stat_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(a * 8 / 2^bits) in Q.24: Taylor series of exp(x/8), squared three times.
  function automatic logic [63:0] exp_q24(int unsigned bits, logic [63:0] a);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    y    = a << (24 - bits);
    term = ONE_Q24;
    acc  = ONE_Q24;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * y) >> 24, 64'(n));
      acc  = acc + term;
    end
    for (int k = 0; k < 3; k++) begin
      acc = (acc * acc) >> 24;
    end
    return acc;
  endfunction

  function automatic logic [PROB_W-1:0] prob_entry(int unsigned bits, int unsigned i);
    int          c;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] pos;
    c   = 2 * int'(i) + 1 - (1 << bits);
    a   = 64'((c < 0) ? -c : c);
    e   = exp_q24(bits, a);
    d   = ONE_Q24 + e;
    pos = udiv64(e * 64'd65536 + (d >> 1), d);
    return (c > 0) ? pos[PROB_W-1:0] : PROB_W'(64'd65536 - pos);
  endfunction

endpackage
`default_nettype wire

[src/ihb_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihb_in_if / ihb_out_if
// Valid/ready channels for site transactions and their results.
// ----------------------------------------------------------------------------
interface ihb_in_if;
  import ihb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [COORD_W-1:0]       col;
  logic [COORD_W-1:0]       row;
  logic                     spin_in;
  logic signed [FIX_W-1:0]  coupling_in;
  logic signed [FIX_W-1:0]  ext_field_in;
  logic [FIX_W-1:0]         uniform;

  modport source (output valid, func, col, row, spin_in, coupling_in, ext_field_in,
                  uniform, input ready);
  modport sink   (input valid, func, col, row, spin_in, coupling_in, ext_field_in,
                  uniform, output ready);
endinterface

interface ihb_out_if;
  import ihb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COORD_W-1:0]       col_out;
  logic [COORD_W-1:0]       row_out;
  logic                     spin_out;
  logic signed [SUM_W-1:0]  local_sum;

  modport source (output valid, col_out, row_out, spin_out, local_sum, input ready);
  modport sink   (input valid, col_out, row_out, spin_out, local_sum, output ready);
endinterface
`default_nettype wire

[src/ihb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihb_ctrl
// Sequencer for one site transaction at a time: fetch, then for an in-range
// update sum, scale and table lookup, and hand-off to the output register.
// ----------------------------------------------------------------------------
module ihb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ihb_pkg::ihb_cmd_t      cmd,
  input  wire ihb_pkg::ihb_stat_t stat
);
  import ihb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_A,
    S_FETCH_B,
    S_SUM,
    S_SCALE,
    S_LOOKUP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_FETCH_A;
        end
      end
      S_FETCH_A: begin
        cmd.fetch_a = 1'b1;
        state_nxt   = stat.update_go ? S_FETCH_B : S_FINISH;
      end
      S_FETCH_B: begin
        cmd.fetch_b = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = ~out_valid_r | out_ready;
        if (cmd.finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[src/ihb_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihb_datapath
// Configuration registers, lattice memories, local field arithmetic, sigmoid
// table and the result register.
// ----------------------------------------------------------------------------
module ihb_datapath #(
  parameter int MAX_WIDTH          = 64,
  parameter int MAX_HEIGHT         = 64,
  parameter int SIGMOID_TABLE_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ihb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ihb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [ihb_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [ihb_pkg::COORD_W-1:0]       in_col,
  input  wire logic [ihb_pkg::COORD_W-1:0]       in_row,
  input  wire logic                              in_spin,
  input  wire logic signed [ihb_pkg::FIX_W-1:0]  in_coupling,
  input  wire logic signed [ihb_pkg::FIX_W-1:0]  in_field,
  input  wire logic [ihb_pkg::FIX_W-1:0]         in_uniform,
  output logic [ihb_pkg::COORD_W-1:0]            out_col,
  output logic [ihb_pkg::COORD_W-1:0]            out_row,
  output logic                                   out_spin,
  output logic signed [ihb_pkg::SUM_W-1:0]       out_local_sum,
  input  wire ihb_pkg::ihb_cmd_t                 cmd,
  output ihb_pkg::ihb_stat_t                     stat
);
  import ihb_pkg::*;

  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int TABLE_SIZE = 1 << SIGMOID_TABLE_BITS;
  localparam int TB         = SIGMOID_TABLE_BITS;

  localparam logic signed [PROD_W-1:0] PROD_LIM = PROD_W'(64'd1 << (ARG_W - 2));

  // Configuration registers.
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [BETA_W-1:0] beta_r;
  logic              fen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      beta_r   <= BETA_RESET;
      fen_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_BETA:   beta_r   <= cfg_wdata[BETA_W-1:0];
        CFG_FIELD:  fen_r    <= cfg_wdata[0];
      endcase
    end
  end

  // Captured transaction.
  logic [FUNC_W-1:0]       func_r;
  logic [COORD_W-1:0]      col_r;
  logic [COORD_W-1:0]      row_r;
  logic                    spin_r;
  logic signed [FIX_W-1:0] coup_in_r;
  logic signed [FIX_W-1:0] field_in_r;
  logic [FIX_W-1:0]        unif_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      col_r      <= in_col;
      row_r      <= in_row;
      spin_r     <= in_spin;
      coup_in_r  <= in_coupling;
      field_in_r <= in_field;
      unif_r     <= in_uniform;
    end
  end

  // Bounds against the clamped lattice size.
  logic col_ok, row_ok, in_range;
  logic left_ok, up_ok, right_ok, down_ok;

  always_comb begin
    if (width_r == '0) begin
      col_ok = (col_r == '0);
    end else begin
      col_ok = (SIZE_W'(col_r) < width_r) && (32'(col_r) < 32'(MAX_WIDTH));
    end
    if (height_r == '0) begin
      row_ok = (row_r == '0);
    end else begin
      row_ok = (SIZE_W'(row_r) < height_r) && (32'(row_r) < 32'(MAX_HEIGHT));
    end
    in_range = col_ok & row_ok;
    left_ok  = (col_r != '0);
    up_ok    = (row_r != '0);
    right_ok = (SIZE_W'(col_r) + SIZE_W'(1) < width_r) &&
               (32'(col_r) + 32'd1 < 32'(MAX_WIDTH));
    down_ok  = (SIZE_W'(row_r) + SIZE_W'(1) < height_r) &&
               (32'(row_r) + 32'd1 < 32'(MAX_HEIGHT));
  end

  assign stat.update_go = in_range && (func_r == FUNC_UPDATE);

  // Site and neighbor addresses.
  logic [ADDR_W-1:0] site_addr;
  logic [ADDR_W-1:0] left_addr, up_addr, right_addr, down_addr;
  logic [ADDR_W-1:0] rd0_addr, rd1_addr;

  always_comb begin
    site_addr  = ADDR_W'(row_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
    left_addr  = left_ok  ? site_addr - ADDR_W'(1)         : site_addr;
    up_addr    = up_ok    ? site_addr - ADDR_W'(MAX_WIDTH) : site_addr;
    right_addr = right_ok ? site_addr + ADDR_W'(1)         : site_addr;
    down_addr  = down_ok  ? site_addr + ADDR_W'(MAX_WIDTH) : site_addr;
    if (cmd.fetch_a) begin
      rd0_addr = (func_r == FUNC_UPDATE) ? left_addr : site_addr;
      rd1_addr = up_addr;
    end else begin
      rd0_addr = right_addr;
      rd1_addr = down_addr;
    end
  end

  // Lattice memories.
  logic                    spin_mem  [DEPTH];
  logic signed [FIX_W-1:0] coup_mem  [DEPTH];
  logic signed [FIX_W-1:0] field_mem [DEPTH];

  logic                    rd0_r, rd1_r;
  logic                    nbr_a0_r, nbr_a1_r;
  logic signed [FIX_W-1:0] coup_rd_r;
  logic signed [FIX_W-1:0] field_rd_r;

  logic spin_we, site_we, spin_wdata;

  always_ff @(posedge clk) begin
    if (cmd.fetch_a || cmd.fetch_b) begin
      rd0_r <= spin_mem[rd0_addr];
      rd1_r <= spin_mem[rd1_addr];
    end
    if (spin_we) begin
      spin_mem[site_addr] <= spin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_a) begin
      coup_rd_r  <= coup_mem[site_addr];
      field_rd_r <= field_mem[site_addr];
    end
    if (site_we) begin
      coup_mem[site_addr]  <= coup_in_r;
      field_mem[site_addr] <= field_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_b) begin
      nbr_a0_r <= rd0_r;
      nbr_a1_r <= rd1_r;
    end
  end

  // Local field: neighbor spin sum times coupling, plus field when enabled.
  logic signed [NBR_W-1:0]  c_left, c_up, c_right, c_down, nbr_sum;
  logic signed [SUM_W:0]    nbr_prod;
  logic signed [SUM_W:0]    field_add;
  logic signed [SUM_W:0]    sum_full;
  logic signed [SUM_W-1:0]  sum_r;

  always_comb begin
    c_left    = left_ok  ? (nbr_a0_r ? 4'sd1 : -4'sd1) : 4'sd0;
    c_up      = up_ok    ? (nbr_a1_r ? 4'sd1 : -4'sd1) : 4'sd0;
    c_right   = right_ok ? (rd0_r    ? 4'sd1 : -4'sd1) : 4'sd0;
    c_down    = down_ok  ? (rd1_r    ? 4'sd1 : -4'sd1) : 4'sd0;
    nbr_sum   = c_left + c_up + c_right + c_down;
    nbr_prod  = nbr_sum * coup_rd_r;
    field_add = fen_r ? {{(SUM_W + 1 - FIX_W){field_rd_r[FIX_W-1]}}, field_rd_r} : '0;
    sum_full  = nbr_prod + field_add;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= sum_full[SUM_W-1:0];
    end
  end

  // Scaled argument beta * local field; the factor two is folded into the index.
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= $signed({1'b0, beta_r}) * sum_r;
    end
  end

  // Saturation, table index and registered table read.
  logic [ARG_W-1:0] biased;
  logic [TB-1:0]    lut_idx;
  logic [PROB_W-1:0] prob_rom [TABLE_SIZE];
  logic [PROB_W-1:0] prob_r;

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
    localparam logic [PROB_W-1:0] ENTRY = prob_entry(SIGMOID_TABLE_BITS, g);
    assign prob_rom[g] = ENTRY;
  end

  always_comb begin
    biased = {~prod_r[ARG_W-2], prod_r[ARG_W-3:0], 1'b0};
    if (prod_r < -PROD_LIM) begin
      lut_idx = '0;
    end else if (prod_r >= PROD_LIM) begin
      lut_idx = '1;
    end else begin
      lut_idx = biased[ARG_W-1 -: TB];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      prob_r <= prob_rom[lut_idx];
    end
  end

  // Result selection and write-back.
  logic                    res_spin;
  logic signed [SUM_W-1:0] res_sum;
  logic                    upd_spin;

  always_comb begin
    upd_spin   = ({1'b0, unif_r} < prob_r);
    res_spin   = 1'b0;
    res_sum    = '0;
    spin_we    = 1'b0;
    site_we    = 1'b0;
    spin_wdata = 1'b0;
    unique case (func_r)
      FUNC_LOAD: begin
        res_spin   = in_range & spin_r;
        spin_we    = cmd.finish & in_range;
        site_we    = cmd.finish & in_range;
        spin_wdata = spin_r;
      end
      FUNC_UPDATE: begin
        res_spin   = in_range & upd_spin;
        res_sum    = in_range ? sum_r : '0;
        spin_we    = cmd.finish & in_range;
        spin_wdata = upd_spin;
      end
      FUNC_READ: begin
        res_spin = in_range & rd0_r;
      end
      default: begin
        res_spin = 1'b0;
      end
    endcase
  end

  logic [COORD_W-1:0]      col_out_r, row_out_r;
  logic                    spin_out_r;
  logic signed [SUM_W-1:0] local_sum_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      col_out_r   <= col_r;
      row_out_r   <= row_r;
      spin_out_r  <= res_spin;
      local_sum_r <= res_sum;
    end
  end

  assign out_col       = col_out_r;
  assign out_row       = row_out_r;
  assign out_spin      = spin_out_r;
  assign out_local_sum = local_sum_r;

endmodule
`default_nettype wire

[src/ising_heat_bath_site_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ising_heat_bath_site_update
// Heat-bath site update engine for a 2D Ising lattice with per-site coupling
// and external field.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. A load or read transaction, or
// an update outside the lattice, passes from capture through the FETCH_A state
// to the result register. An in-range update goes through more states: the
// spin memory has two read ports, so the four neighbor spins need two fetch
// states (FETCH_A, FETCH_B), followed by one state each for the coupling
// product, the beta multiply, the registered sigmoid table read and the result
// register. The next transaction is accepted once the result register has been
// written. A finished result sits in the output register, and the next
// transaction is accepted while it waits there; the following result stalls
// until that register is free. The lattice memories are not cleared at reset;
// every site must be loaded before it is read or used in an update.
module ising_heat_bath_site_update #(
  parameter int MAX_WIDTH          = 64,
  parameter int MAX_HEIGHT         = 64,
  parameter int SIGMOID_TABLE_BITS = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ihb_in_if.sink                              in_ch,
  ihb_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ihb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ihb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ihb_pkg::*;

  ihb_cmd_t  cmd;
  ihb_stat_t stat;

  ihb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ihb_datapath #(
    .MAX_WIDTH          (MAX_WIDTH),
    .MAX_HEIGHT         (MAX_HEIGHT),
    .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_func       (in_ch.func),
    .in_col        (in_ch.col),
    .in_row        (in_ch.row),
    .in_spin       (in_ch.spin_in),
    .in_coupling   (in_ch.coupling_in),
    .in_field      (in_ch.ext_field_in),
    .in_uniform    (in_ch.uniform),
    .out_col       (out_ch.col_out),
    .out_row       (out_ch.row_out),
    .out_spin      (out_ch.spin_out),
    .out_local_sum (out_ch.local_sum),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
`default_nettype wire
